/* hdl/smsd_pkg.sv */
package smsd_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int SAMPLE_W    = 32;

	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W  = ADDR_W + 1;
	// running sum of up to MAX_SAMPLES signed samples
	localparam int SUM_W  = SAMPLE_W + ADDR_W;
	// sum of squared deviations: each square below 2^(2*SAMPLE_W)
	localparam int DIV_W  = 2 * SAMPLE_W + ADDR_W;
	localparam int STEP_W = $clog2(DIV_W + 1);

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_SINGLE  = 2'd1;
	localparam logic [1:0] STAT_DROPPED = 2'd2;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] mean;
		logic [31:0]        std_dev;
		logic [10:0]        sample_count;
		logic [1:0]         status;
	} result_t;

endpackage

/* hdl/sample_mean_std_deviation.sv */
// Sample mean and sample standard deviation, two passes over a sample store.
//
// Input: an item is taken at a rising edge with start high and busy low.
// Each item carries one signed Q16.16 sample and a last flag. Items without
// last are stored as they are taken and busy stays low, so samples load at
// one per clock. Once 1024 samples are held, further samples are dropped and
// the set reports status 2.
// An item with last starts the end-of-set work and raises busy: the mean is
// formed by a shared restoring divider (one quotient bit a cycle), then a
// pipelined pass reads the store once per cycle, squaring deviations from
// the mean, the divider runs again on the sum of squares by n - 1 and a
// digit-by-digit square root follows. The result strobe done rises at the
// end; a one-sample set skips the pass, the second division and the root.
// done is high for exactly one cycle; the receiver cannot stall it. busy
// falls in the same cycle, so the next set may start right away.
// Reset clears the count, the sum and the sequencer; the store itself is
// not cleared, since only entries written in the current set are read.
module sample_mean_std_deviation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  smsd_pkg::item_t     item,
	output logic                busy,
	output logic                done,
	output smsd_pkg::result_t   result
);
	import smsd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV_MEAN,
		ST_FIX,
		ST_PASS,
		ST_DIV_VAR,
		ST_SQRT
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]       kept_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                   ovf_q;
	logic                   done_q;
	result_t                result_q;

	// shared divider
	logic [DIV_W-1:0]  div_num_q;
	logic [CNT_W-1:0]  div_rem_q;
	logic [CNT_W-1:0]  div_den_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic signed [SAMPLE_W-1:0] mean_q;

	// pass pipeline
	logic [CNT_W-1:0]    idx_q;
	logic                v_s1, v_s2, v_s3;
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic [SAMPLE_W-1:0] absd_s2;
	logic [2*SAMPLE_W-1:0] prod_s3;
	logic [DIV_W-1:0]    acc_q;

	// square root
	logic [2*SAMPLE_W-1:0] sq_x_q;
	logic [SAMPLE_W+1:0]   sq_rem_q;
	logic [SAMPLE_W-1:0]   sq_root_q;
	logic                  sat_q;

	logic [SAMPLE_W-1:0] store_q [MAX_SAMPLES];

	logic accept;
	logic store_we;
	logic issue;
	logic signed [SUM_W-1:0] sum_nx;
	logic [SUM_W-1:0] sum_mag;

	logic [CNT_W:0]     div_part;
	logic [CNT_W:0]     div_diff;
	logic               div_ge;
	logic [CNT_W-1:0]   div_rem_nx;
	logic [DIV_W-1:0]   div_num_nx;

	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0]        diff_abs;

	logic [SAMPLE_W+3:0] sq_cand;
	logic [SAMPLE_W+3:0] sq_trial;
	logic                sq_ge;
	logic [SAMPLE_W+1:0] sq_rem_nx;
	logic [SAMPLE_W-1:0] sq_root_nx;

	logic [1:0] status_now;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign accept   = start && (state_q == ST_IDLE);
	assign store_we = accept && (kept_q < CNT_W'(MAX_SAMPLES));
	assign issue    = (state_q == ST_PASS) && (idx_q < kept_q);

	assign sum_nx  = sum_q + {{ADDR_W{item.sample[SAMPLE_W-1]}}, item.sample[SAMPLE_W-1:0]};
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	always_comb begin
		div_part   = {div_rem_q, div_num_q[DIV_W-1]};
		div_diff   = div_part - {1'b0, div_den_q};
		div_ge     = !div_diff[CNT_W];
		div_rem_nx = div_ge ? div_diff[CNT_W-1:0] : div_part[CNT_W-1:0];
		div_num_nx = {div_num_q[DIV_W-2:0], div_ge};
	end

	always_comb begin
		diff     = $signed({rd_data_s1[SAMPLE_W-1], rd_data_s1}) -
		           $signed({mean_q[SAMPLE_W-1], mean_q});
		diff_abs = diff[SAMPLE_W] ? -diff : diff;
	end

	always_comb begin
		sq_cand    = {sq_rem_q, sq_x_q[2*SAMPLE_W-1 -: 2]};
		sq_trial   = {2'b00, sq_root_q, 2'b01};
		sq_ge      = (sq_cand >= sq_trial);
		sq_rem_nx  = sq_ge ? (SAMPLE_W+2)'(sq_cand - sq_trial) : sq_cand[SAMPLE_W+1:0];
		sq_root_nx = {sq_root_q[SAMPLE_W-2:0], sq_ge};
	end

	always_comb begin
		priority if (ovf_q) begin
			status_now = STAT_DROPPED;
		end else if (kept_q < CNT_W'(2)) begin
			status_now = STAT_SINGLE;
		end else begin
			status_now = STAT_OK;
		end
	end

	// sample store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[kept_q[ADDR_W-1:0]] <= item.sample[SAMPLE_W-1:0];
		end
		rd_data_s1 <= store_q[idx_q[ADDR_W-1:0]];
	end

	// datapath pipeline registers
	always_ff @(posedge clk) begin
		absd_s2 <= diff_abs[SAMPLE_W-1:0];
		prod_s3 <= absd_s2 * absd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kept_q    <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
			done_q    <= 1'b0;
			result_q  <= '0;
			div_num_q <= '0;
			div_rem_q <= '0;
			div_den_q <= '0;
			step_q    <= '0;
			neg_q     <= 1'b0;
			mean_q    <= '0;
			idx_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			acc_q     <= '0;
			sq_x_q    <= '0;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
			sat_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (store_we) begin
							kept_q <= kept_q + CNT_W'(1);
							sum_q  <= sum_nx;
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					div_num_q <= DIV_W'(sum_mag);
					div_rem_q <= '0;
					div_den_q <= kept_q;
					neg_q     <= sum_q[SUM_W-1];
					step_q    <= '0;
					state_q   <= ST_DIV_MEAN;
				end
				ST_DIV_MEAN: begin
					div_num_q <= div_num_nx;
					div_rem_q <= div_rem_nx;
					step_q    <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_W - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					mean_q <= neg_q ? -$signed(div_num_q[SAMPLE_W-1:0])
					                : $signed(div_num_q[SAMPLE_W-1:0]);
					if (kept_q >= CNT_W'(2)) begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_PASS;
					end else begin
						// single sample: mean is that sample, no deviation
						result_q.mean         <= neg_q ?
							-$signed(div_num_q[SAMPLE_W-1:0]) :
							$signed(div_num_q[SAMPLE_W-1:0]);
						result_q.std_dev      <= '0;
						result_q.sample_count <= 11'(kept_q);
						result_q.status       <= status_now;
						done_q  <= 1'b1;
						kept_q  <= '0;
						sum_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_PASS: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (v_s3) begin
						acc_q <= acc_q + DIV_W'(prod_s3);
					end
					if (!issue && !v_s1 && !v_s2 && !v_s3) begin
						div_num_q <= acc_q;
						div_rem_q <= '0;
						div_den_q <= kept_q - CNT_W'(1);
						step_q    <= '0;
						state_q   <= ST_DIV_VAR;
					end
				end
				ST_DIV_VAR: begin
					div_num_q <= div_num_nx;
					div_rem_q <= div_rem_nx;
					if (step_q == STEP_W'(DIV_W - 1)) begin
						sq_x_q    <= div_num_nx[2*SAMPLE_W-1:0];
						sat_q     <= |div_num_nx[DIV_W-1:2*SAMPLE_W];
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						step_q    <= '0;
						state_q   <= ST_SQRT;
					end else begin
						step_q    <= step_q + STEP_W'(1);
					end
				end
				ST_SQRT: begin
					sq_x_q    <= {sq_x_q[2*SAMPLE_W-3:0], 2'b00};
					sq_rem_q  <= sq_rem_nx;
					sq_root_q <= sq_root_nx;
					step_q    <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SAMPLE_W - 1)) begin
						result_q.mean         <= mean_q;
						result_q.std_dev      <= sat_q ? '1 : sq_root_nx;
						result_q.sample_count <= 11'(kept_q);
						result_q.status       <= status_now;
						done_q  <= 1'b1;
						kept_q  <= '0;
						sum_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
